/* hdl/cts_pkg.sv */
// Shared types, constants and the divider step for the control to step period block.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package cts_pkg;

    localparam int CONTROL_FRAC_BITS = 8;

    // Reset values of the scaled registers follow the control fraction width
    localparam int FS_RAW = 24 << CONTROL_FRAC_BITS;
    localparam logic [14:0] FULL_SCALE_RESET = 15'((FS_RAW > 32767) ? 32767 : FS_RAW);
    localparam logic [14:0] STOP_THRESHOLD_RESET = 15'(((1 << CONTROL_FRAC_BITS) + 5) / 10);

    localparam logic [27:0] BUS_CLOCK_RESET = 28'd120000000;
    localparam logic [15:0] PRESCALER_RESET = 16'd0;
    localparam logic [15:0] MIN_STEP_RESET  = 16'd200;
    localparam logic [15:0] MAX_STEP_RESET  = 16'd15000;
    localparam logic [15:0] MIN_RELOAD_RESET = 16'd10;

    localparam logic [21:0] RELOAD_MAX = 22'h3FFFFF;

    // Restoring divider geometry: one quotient bit per stage
    localparam int DIV_NW     = 32;
    localparam int DIV_DW     = 17;
    localparam int DIV_STAGES = DIV_NW;

    typedef enum logic [2:0] {
        REG_BUS_CLOCK  = 3'd0,
        REG_PRESCALER  = 3'd1,
        REG_MIN_STEP   = 3'd2,
        REG_MAX_STEP   = 3'd3,
        REG_FULL_SCALE = 3'd4,
        REG_STOP_THR   = 3'd5,
        REG_MIN_RELOAD = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [DIV_DW-1:0] rem;
        logic [DIV_NW-1:0] nq;
    } div_t;

    // Per-word control travelling beside the datapath
    typedef struct packed {
        logic       valid;
        logic       dir;
        logic       stop;
        logic [1:0] chan;
        logic       use_hi;
    } side_t;

    function automatic div_t div_step(input logic [DIV_DW-1:0] r,
                                      input logic [DIV_NW-1:0] nq,
                                      input logic [DIV_DW-1:0] d);
        logic [DIV_DW:0] sh;
        div_t            res;
        sh = {r, nq[DIV_NW-1]};
        if (sh >= {1'b0, d})
        begin
            res.rem = DIV_DW'(sh - {1'b0, d});
            res.nq  = {nq[DIV_NW-2:0], 1'b1};
        end
        else
        begin
            res.rem = sh[DIV_DW-1:0];
            res.nq  = {nq[DIV_NW-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* hdl/control_to_step_period.sv */
// Control to step period: one word in per cycle while the output is not stalled, one
// result per word (input stage, multiply, 32-stage dividers for the scaled frequency
// and the timer clock, frequency clamp, a further 32-stage divider for the reload,
// output register). A stall on the output freezes the whole pipeline and stalls the
// input in the same cycle. Configuration registers feed the input, multiply, clamp
// and output stages directly and must only change while no word is in flight.
module control_to_step_period (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [27:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] control_volts,
    input  logic [1:0]         channel,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               direction_forward,
    output logic               stopped,
    output logic [21:0]        reload_value,
    output logic [20:0]        compare_value,
    output logic [1:0]         out_channel
);

    logic [27:0] bus_clock_reg;
    logic [15:0] prescaler_reg;
    logic [15:0] min_step_reg;
    logic [15:0] max_step_reg;
    logic [14:0] full_scale_reg;
    logic [14:0] stop_thr_reg;
    logic [15:0] min_reload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_clock_reg  <= cts_pkg::BUS_CLOCK_RESET;
            prescaler_reg  <= cts_pkg::PRESCALER_RESET;
            min_step_reg   <= cts_pkg::MIN_STEP_RESET;
            max_step_reg   <= cts_pkg::MAX_STEP_RESET;
            full_scale_reg <= cts_pkg::FULL_SCALE_RESET;
            stop_thr_reg   <= cts_pkg::STOP_THRESHOLD_RESET;
            min_reload_reg <= cts_pkg::MIN_RELOAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cts_pkg::cfg_reg_t'(cfg_index))
                cts_pkg::REG_BUS_CLOCK:  bus_clock_reg  <= cfg_data;
                cts_pkg::REG_PRESCALER:  prescaler_reg  <= cfg_data[15:0];
                cts_pkg::REG_MIN_STEP:   min_step_reg   <= cfg_data[15:0];
                cts_pkg::REG_MAX_STEP:   max_step_reg   <= cfg_data[15:0];
                cts_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_data[14:0];
                cts_pkg::REG_STOP_THR:   stop_thr_reg   <= cfg_data[14:0];
                cts_pkg::REG_MIN_RELOAD: min_reload_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage 0: magnitude, stop test, clip to full scale
    logic [15:0] mag;
    logic [16:0] span;
    logic [14:0] m_next;
    cts_pkg::side_t side0_next;

    always_comb
    begin
        mag  = control_volts[15] ? (~control_volts + 16'd1) : control_volts;
        span = {1'b0, max_step_reg} - {1'b0, min_step_reg};
        m_next = (mag > {1'b0, full_scale_reg}) ? full_scale_reg : mag[14:0];
        side0_next.valid  = in_valid;
        side0_next.dir    = !control_volts[15];
        side0_next.stop   = mag < {1'b0, stop_thr_reg};
        side0_next.chan   = channel;
        side0_next.use_hi = span[16] || (full_scale_reg == 15'd0);
    end

    cts_pkg::side_t side0_reg, side1_reg, side2_reg;
    cts_pkg::side_t sidea_reg [cts_pkg::DIV_STAGES];
    cts_pkg::side_t sideb_reg [cts_pkg::DIV_STAGES];
    logic [14:0] m0_reg;
    logic [30:0] num1_reg;
    logic [28:0] tnum1_reg;
    logic [16:0] tden1_reg;
    logic [15:0] f2_reg;
    logic [28:0] tclk2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side0_reg.valid <= 1'b0;
            side1_reg.valid <= 1'b0;
            side2_reg.valid <= 1'b0;
            for (int k = 0; k < cts_pkg::DIV_STAGES; k++)
            begin
                sidea_reg[k].valid <= 1'b0;
                sideb_reg[k].valid <= 1'b0;
            end
        end
        else if (adv)
        begin
            side0_reg <= side0_next;
            side1_reg <= side0_reg;
            sidea_reg[0] <= side1_reg;
            side2_reg <= sidea_reg[cts_pkg::DIV_STAGES-1];
            sideb_reg[0] <= side2_reg;
            for (int k = 1; k < cts_pkg::DIV_STAGES; k++)
            begin
                sidea_reg[k] <= sidea_reg[k-1];
                sideb_reg[k] <= sideb_reg[k-1];
            end
        end
    end

    // Stage 1: scaled numerator and timer clock operands
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_reg    <= m_next;
            num1_reg  <= 31'(m0_reg * span[15:0]);
            tnum1_reg <= {bus_clock_reg, 1'b0};
            tden1_reg <= {1'b0, prescaler_reg} + 17'd1;
        end
    end

    logic [31:0] qa;
    logic [31:0] qt;
    logic [31:0] qb;

    cts_div u_div_freq (
        .clk (clk),
        .en  (adv),
        .num ({1'b0, num1_reg}),
        .den ({2'b00, full_scale_reg}),
        .quo (qa)
    );

    cts_div u_div_tclk (
        .clk (clk),
        .en  (adv),
        .num ({3'b000, tnum1_reg}),
        .den (tden1_reg),
        .quo (qt)
    );

    // Frequency: min plus offset, or max if max < min or full scale is 0; at least 1
    logic [15:0] f_next;
    always_comb
    begin
        if (sidea_reg[cts_pkg::DIV_STAGES-1].use_hi)
            f_next = max_step_reg;
        else
            f_next = min_step_reg + qa[15:0];
        if (f_next == 16'd0)
            f_next = 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg    <= f_next;
            tclk2_reg <= qt[28:0];
        end
    end

    cts_div u_div_reload (
        .clk (clk),
        .en  (adv),
        .num ({3'b000, tclk2_reg}),
        .den ({1'b0, f2_reg}),
        .quo (qb)
    );

    // Output stage: reload from quotient minus one, floor, saturate, zero when stopped
    cts_pkg::side_t side_out;
    logic [28:0] rl;
    logic [21:0] reload_next;
    always_comb
    begin
        side_out = sideb_reg[cts_pkg::DIV_STAGES-1];
        rl = (qb[28:0] == 29'd0) ? {13'd0, min_reload_reg} : (qb[28:0] - 29'd1);
        if (rl < {13'd0, min_reload_reg})
            rl = {13'd0, min_reload_reg};
        if (rl > {7'd0, cts_pkg::RELOAD_MAX})
            rl = {7'd0, cts_pkg::RELOAD_MAX};
        reload_next = side_out.stop ? 22'd0 : rl[21:0];
    end

    logic        dir_reg;
    logic        stop_reg;
    logic [21:0] reload_reg;
    logic [1:0]  chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= side_out.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dir_reg    <= side_out.dir;
            stop_reg   <= side_out.stop;
            reload_reg <= reload_next;
            chan_reg   <= side_out.chan;
        end
    end

    assign out_valid         = out_valid_reg;
    assign direction_forward = dir_reg;
    assign stopped           = stop_reg;
    assign reload_value      = reload_reg;
    assign compare_value     = reload_reg[21:1];
    assign out_channel       = chan_reg;

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped) |-> (reload_value == 22'd0))
        else $error("stopped word carries a nonzero reload");

    a_reload_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !stopped) |-> (reload_value >= {6'd0, min_reload_reg}))
        else $error("reload below the configured floor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(reload_value)))
        else $error("stalled result changed");

    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked output");

endmodule

/* hdl/cts_div.sv */
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Uses cts_pkg for widths and the step function; advances only on en.
module cts_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [cts_pkg::DIV_NW-1:0]  num,
    input  logic [cts_pkg::DIV_DW-1:0]  den,
    output logic [cts_pkg::DIV_NW-1:0]  quo
);

    logic [cts_pkg::DIV_DW-1:0] rem_reg [cts_pkg::DIV_STAGES];
    logic [cts_pkg::DIV_NW-1:0] nq_reg  [cts_pkg::DIV_STAGES];
    logic [cts_pkg::DIV_DW-1:0] den_reg [cts_pkg::DIV_STAGES];
    cts_pkg::div_t              step_next [cts_pkg::DIV_STAGES];

    always_comb
    begin
        step_next[0] = cts_pkg::div_step('0, num, den);
        for (int k = 1; k < cts_pkg::DIV_STAGES; k++)
        begin
            step_next[k] = cts_pkg::div_step(rem_reg[k-1], nq_reg[k-1], den_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            for (int k = 0; k < cts_pkg::DIV_STAGES; k++)
            begin
                rem_reg[k] <= step_next[k].rem;
                nq_reg[k]  <= step_next[k].nq;
            end
            for (int k = 1; k < cts_pkg::DIV_STAGES; k++)
            begin
                den_reg[k] <= den_reg[k-1];
            end
        end
    end

    assign quo = nq_reg[cts_pkg::DIV_STAGES-1];

endmodule
